// File: hw/rtl/ffa_pkg.sv
// Package: shared constants, types and status codes for the first-fit allocator.
package ffa_pkg;

   localparam int MaxSegmentsDefault = 64;
   localparam int HeaderBytesDefault = 40;
   localparam int AddrBitsDefault    = 20;
   localparam int AlignBytes         = 8;
   localparam int ArenaCap           = 1048576;
   localparam int SizeBits           = 21;
   localparam int OffsetBits         = 20;
   localparam logic [SizeBits-1:0] ArenaResetBytes = 21'd65536;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_NOFIT   = 2'd1,
      ST_IGNORED = 2'd2,
      ST_BADFREE = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      ACT_ALLOC = 1'b0,
      ACT_FREE  = 1'b1
   } action_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN_REQ,
      S_SCAN_CHK,
      S_SHIFT_UP_RD,
      S_SHIFT_UP_WR,
      S_SPLIT,
      S_FREE_NEXT,
      S_FREE_NEXT_CHK,
      S_FREE_PREV,
      S_FREE_PREV_CHK,
      S_SHIFT_DN_RD,
      S_SHIFT_DN_WR,
      S_DONE
   } fsm_state_type;

endpackage

// File: hw/rtl/ffa_seg_table.sv
// Segment table memory: start, size and free mark per entry, one write and one read port.
module ffa_seg_table #(
   parameter int MAX_SEGMENTS = ffa_pkg::MaxSegmentsDefault,
   parameter int ADDR_BITS    = ffa_pkg::AddrBitsDefault,
   localparam int IdxBits     = $clog2(MAX_SEGMENTS)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [IdxBits-1:0]          wr_idx,
   input  logic [ADDR_BITS-1:0]        wr_start,
   input  logic [ffa_pkg::SizeBits-1:0] wr_size,
   input  logic                        wr_free,
   input  logic [IdxBits-1:0]          rd_idx,
   output logic [ADDR_BITS-1:0]        rd_start,
   output logic [ffa_pkg::SizeBits-1:0] rd_size,
   output logic                        rd_free
);

   logic [ADDR_BITS+ffa_pkg::SizeBits:0] mem_ff [MAX_SEGMENTS];
   logic [ADDR_BITS+ffa_pkg::SizeBits:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_idx] <= {wr_start, wr_size, wr_free};
      end
      rd_ff <= mem_ff[rd_idx];
   end

   assign {rd_start, rd_size, rd_free} = rd_ff;

endmodule

// File: hw/rtl/ffa_ctrl.sv
// Sequencer: table walk, split, coalesce and entry shifting; several states share one adder (add_sum).
module ffa_ctrl #(
   parameter int MAX_SEGMENTS = ffa_pkg::MaxSegmentsDefault,
   parameter int HEADER_BYTES = ffa_pkg::HeaderBytesDefault,
   parameter int ADDR_BITS    = ffa_pkg::AddrBitsDefault,
   localparam int IdxBits     = $clog2(MAX_SEGMENTS),
   localparam int CntBits     = $clog2(MAX_SEGMENTS + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [ffa_pkg::SizeBits-1:0]  csr_wdata,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_action,
   input  logic [ffa_pkg::SizeBits-1:0]  req_request_bytes,
   input  logic [ffa_pkg::OffsetBits-1:0] req_payload_offset,
   output logic                          rsp_strobe,
   output logic [1:0]                    rsp_status
);

   localparam int SB = ffa_pkg::SizeBits;
   localparam int WB = SB + 2;  // wide enough for need + header + 16

   localparam logic [WB-1:0] HdrW   = WB'(HEADER_BYTES);
   localparam logic [WB-1:0] SplitW = WB'(HEADER_BYTES + 2 * ffa_pkg::AlignBytes);
   localparam logic [WB-1:0] AlnM   = WB'(ffa_pkg::AlignBytes - 1);
   localparam logic [WB-1:0] CapW   = (ADDR_BITS < $clog2(ffa_pkg::ArenaCap))
                                      ? (WB'(1) << ADDR_BITS) : WB'(ffa_pkg::ArenaCap);

   ffa_pkg::fsm_state_type state_ff, state_in;

   logic [SB-1:0]         arena_ff, arena_in;
   logic                  init_ff, init_in;     // entry 0 overridden until written
   logic [CntBits-1:0]    count_ff, count_in;
   logic [SB-1:0]         used_ff, used_in;
   logic [SB-1:0]         peak_ff, peak_in;
   logic [CntBits-1:0]    idx_ff, idx_in;       // found entry
   logic [CntBits-1:0]    ptr_ff, ptr_in;       // walking pointer
   logic                  act_ff, act_in;
   logic [WB-1:0]         need_ff, need_in;
   logic [ADDR_BITS-1:0]  off_ff, off_in;
   logic [ADDR_BITS-1:0]  cur_start_ff, cur_start_in;
   logic [SB-1:0]         cur_size_ff, cur_size_in;
   logic [1:0]            status_ff, status_in;
   logic                  strobe_ff, strobe_in;

   logic                  wr_en;
   logic [IdxBits-1:0]    wr_idx, rd_idx;
   logic [ADDR_BITS-1:0]  wr_start, rd_start_raw, rd_start;
   logic [SB-1:0]         wr_size, rd_size_raw, rd_size;
   logic                  wr_free, rd_free_raw, rd_free;
   logic                  rd_zero_ff;

   // shared adder
   logic [WB-1:0]         add_a, add_b, add_sum;
   assign add_sum = add_a + add_b;

   logic [WB-1:0] arena_al;
   always_comb begin
      arena_al = (WB'(arena_ff) + AlnM) & ~AlnM;
      if (arena_al > CapW) arena_al = CapW & ~AlnM;
   end

   ffa_seg_table #(.MAX_SEGMENTS(MAX_SEGMENTS), .ADDR_BITS(ADDR_BITS)) u_table (
      .clock(clock), .wr_en(wr_en), .wr_idx(wr_idx), .wr_start(wr_start),
      .wr_size(wr_size), .wr_free(wr_free), .rd_idx(rd_idx),
      .rd_start(rd_start_raw), .rd_size(rd_size_raw), .rd_free(rd_free_raw));

   always_ff @(posedge clock) begin
      rd_zero_ff <= (rd_idx == '0);
   end

   always_comb begin
      if (init_ff && rd_zero_ff) begin
         rd_start = '0;
         rd_size  = arena_al[SB-1:0];
         rd_free  = 1'b1;
      end else begin
         rd_start = rd_start_raw;
         rd_size  = rd_size_raw;
         rd_free  = rd_free_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ffa_pkg::S_IDLE;
         arena_ff  <= ffa_pkg::ArenaResetBytes;
         init_ff   <= 1'b1;
         count_ff  <= CntBits'(1);
         used_ff   <= '0;
         peak_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         arena_ff  <= arena_in;
         init_ff   <= init_in;
         count_ff  <= count_in;
         used_ff   <= used_in;
         peak_ff   <= peak_in;
         strobe_ff <= strobe_in;
      end
      idx_ff       <= idx_in;
      ptr_ff       <= ptr_in;
      act_ff       <= act_in;
      need_ff      <= need_in;
      off_ff       <= off_in;
      cur_start_ff <= cur_start_in;
      cur_size_ff  <= cur_size_in;
      status_ff    <= status_in;
   end

   always_comb begin
      state_in     = state_ff;
      arena_in     = arena_ff;
      init_in      = init_ff;
      count_in     = count_ff;
      used_in      = used_ff;
      peak_in      = peak_ff;
      idx_in       = idx_ff;
      ptr_in       = ptr_ff;
      act_in       = act_ff;
      need_in      = need_ff;
      off_in       = off_ff;
      cur_start_in = cur_start_ff;
      cur_size_in  = cur_size_ff;
      status_in    = status_ff;
      strobe_in    = 1'b0;
      wr_en        = 1'b0;
      wr_idx       = ptr_ff[IdxBits-1:0];
      wr_start     = rd_start;
      wr_size      = rd_size;
      wr_free      = rd_free;
      rd_idx       = ptr_ff[IdxBits-1:0];
      add_a        = WB'(req_request_bytes);
      add_b        = HdrW + AlnM;
      busy         = (state_ff != ffa_pkg::S_IDLE);

      unique case (state_ff)
         ffa_pkg::S_IDLE: begin
            if (csr_write) begin
               arena_in = csr_wdata;
               init_in  = 1'b1;
               count_in = CntBits'(1);
               used_in  = '0;
               peak_in  = '0;
            end else if (start) begin
               act_in  = req_action;
               need_in = add_sum & ~AlnM;
               off_in  = ADDR_BITS'(req_payload_offset);
               ptr_in  = '0;
               rd_idx  = '0;
               if ((req_action == ffa_pkg::ACT_ALLOC && req_request_bytes == '0) ||
                   (req_action == ffa_pkg::ACT_FREE && req_payload_offset == '0)) begin
                  status_in = ffa_pkg::ST_IGNORED;
                  state_in  = ffa_pkg::S_DONE;
               end else if (ffa_pkg::OffsetBits > ADDR_BITS && req_action == ffa_pkg::ACT_FREE
                            && (WB'(req_payload_offset) >> ADDR_BITS) != '0) begin
                  status_in = ffa_pkg::ST_BADFREE;
                  state_in  = ffa_pkg::S_DONE;
               end else begin
                  state_in = ffa_pkg::S_SCAN_CHK;
               end
            end
         end
         ffa_pkg::S_SCAN_REQ: begin
            state_in = ffa_pkg::S_SCAN_CHK;
         end
         ffa_pkg::S_SCAN_CHK: begin
            // header + start compare for free, size compare for alloc
            add_a = WB'(rd_start);
            add_b = HdrW;
            cur_start_in = rd_start;
            cur_size_in  = rd_size;
            idx_in       = ptr_ff;
            if (ptr_ff >= count_ff) begin
               status_in = act_ff ? ffa_pkg::ST_BADFREE : ffa_pkg::ST_NOFIT;
               state_in  = ffa_pkg::S_DONE;
            end else if (act_ff == ffa_pkg::ACT_ALLOC && rd_free && WB'(rd_size) >= need_ff) begin
               if (WB'(rd_size) >= need_ff + SplitW && count_ff < CntBits'(MAX_SEGMENTS)) begin
                  ptr_in   = count_ff - CntBits'(1);
                  state_in = ffa_pkg::S_SHIFT_UP_RD;
               end else begin
                  state_in = ffa_pkg::S_SPLIT;
               end
            end else if (act_ff == ffa_pkg::ACT_FREE && !rd_free &&
                         add_sum == WB'(off_ff)) begin
               state_in = ffa_pkg::S_FREE_NEXT;
            end else begin
               ptr_in   = ptr_ff + CntBits'(1);
               rd_idx   = IdxBits'(ptr_ff + CntBits'(1));
               state_in = ffa_pkg::S_SCAN_REQ;
            end
         end
         ffa_pkg::S_SHIFT_UP_RD: begin
            // ptr points at source entry to move up by one
            if (ptr_ff == idx_ff) begin
               state_in = ffa_pkg::S_SPLIT;
            end else begin
               state_in = ffa_pkg::S_SHIFT_UP_WR;
            end
         end
         ffa_pkg::S_SHIFT_UP_WR: begin
            wr_en    = 1'b1;
            wr_idx   = IdxBits'(ptr_ff + CntBits'(1));
            ptr_in   = ptr_ff - CntBits'(1);
            rd_idx   = IdxBits'(ptr_ff - CntBits'(1));
            if (ptr_ff == CntBits'(1)) init_in = 1'b0;
            state_in = ffa_pkg::S_SHIFT_UP_RD;
         end
         ffa_pkg::S_SPLIT: begin
            // phase A: write remainder (if splitting), then allocated entry
            if (WB'(cur_size_ff) >= need_ff + SplitW && count_ff < CntBits'(MAX_SEGMENTS)
                && ptr_ff == idx_ff) begin
               add_a    = WB'(cur_start_ff);
               add_b    = need_ff;
               wr_en    = 1'b1;
               wr_idx   = IdxBits'(idx_ff + CntBits'(1));
               wr_start = ADDR_BITS'(add_sum);
               wr_size  = cur_size_ff - need_ff[SB-1:0];
               wr_free  = 1'b1;
               count_in = count_ff + CntBits'(1);
               cur_size_in = need_ff[SB-1:0];
               ptr_in   = '1;  // mark remainder written
            end else begin
               add_a    = WB'(used_ff);
               add_b    = WB'(cur_size_ff);
               wr_en    = 1'b1;
               wr_idx   = idx_ff[IdxBits-1:0];
               wr_start = cur_start_ff;
               wr_size  = cur_size_ff;
               wr_free  = 1'b0;
               if (idx_ff == '0) init_in = 1'b0;
               used_in  = add_sum[SB-1:0];
               if (add_sum[SB-1:0] > peak_ff) peak_in = add_sum[SB-1:0];
               status_in = ffa_pkg::ST_DONE;
               state_in  = ffa_pkg::S_DONE;
            end
         end
         ffa_pkg::S_FREE_NEXT: begin
            used_in = used_ff - cur_size_ff;
            ptr_in  = idx_ff + CntBits'(1);
            rd_idx  = IdxBits'(idx_ff + CntBits'(1));
            state_in = ffa_pkg::S_FREE_NEXT_CHK;
         end
         ffa_pkg::S_FREE_NEXT_CHK: begin
            add_a = WB'(cur_size_ff);
            add_b = WB'(rd_size);
            if (ptr_ff < count_ff && rd_free) begin
               cur_size_in = add_sum[SB-1:0];
               ptr_in      = ptr_ff;  // removal of ptr entry, then prev check
               idx_in      = idx_ff;
               need_in     = '0;       // flag: prev check pending
               rd_idx      = IdxBits'(ptr_ff + CntBits'(1));
               ptr_in      = ptr_ff + CntBits'(1);
               state_in    = ffa_pkg::S_SHIFT_DN_RD;
            end else begin
               state_in = ffa_pkg::S_FREE_PREV;
            end
         end
         ffa_pkg::S_FREE_PREV: begin
            // write merged entry, then look at predecessor
            wr_en    = 1'b1;
            wr_idx   = idx_ff[IdxBits-1:0];
            wr_start = cur_start_ff;
            wr_size  = cur_size_ff;
            wr_free  = 1'b1;
            if (idx_ff == '0) init_in = 1'b0;
            if (idx_ff == '0) begin
               status_in = ffa_pkg::ST_DONE;
               state_in  = ffa_pkg::S_DONE;
            end else begin
               rd_idx   = IdxBits'(idx_ff - CntBits'(1));
               ptr_in   = idx_ff - CntBits'(1);
               state_in = ffa_pkg::S_FREE_PREV_CHK;
            end
         end
         ffa_pkg::S_FREE_PREV_CHK: begin
            add_a = WB'(cur_size_ff);
            add_b = WB'(rd_size);
            if (rd_free) begin
               wr_en    = 1'b1;
               wr_idx   = ptr_ff[IdxBits-1:0];
               wr_start = rd_start;
               wr_size  = add_sum[SB-1:0];
               wr_free  = 1'b1;
               need_in  = '1;  // flag: no more prev check
               ptr_in   = idx_ff + CntBits'(1);
               rd_idx   = IdxBits'(idx_ff + CntBits'(1));
               state_in = ffa_pkg::S_SHIFT_DN_RD;
            end else begin
               status_in = ffa_pkg::ST_DONE;
               state_in  = ffa_pkg::S_DONE;
            end
         end
         ffa_pkg::S_SHIFT_DN_RD: begin
            // ptr is source; it moves to ptr-1
            if (ptr_ff >= count_ff) begin
               count_in = count_ff - CntBits'(1);
               if (need_ff == '0) begin
                  state_in = ffa_pkg::S_FREE_PREV;
               end else begin
                  status_in = ffa_pkg::ST_DONE;
                  state_in  = ffa_pkg::S_DONE;
               end
            end else begin
               state_in = ffa_pkg::S_SHIFT_DN_WR;
            end
         end
         ffa_pkg::S_SHIFT_DN_WR: begin
            wr_en    = 1'b1;
            wr_idx   = IdxBits'(ptr_ff - CntBits'(1));
            ptr_in   = ptr_ff + CntBits'(1);
            rd_idx   = IdxBits'(ptr_ff + CntBits'(1));
            state_in = ffa_pkg::S_SHIFT_DN_RD;
         end
         ffa_pkg::S_DONE: begin
            strobe_in = 1'b1;
            state_in  = ffa_pkg::S_IDLE;
         end
         default: state_in = ffa_pkg::S_IDLE;
      endcase
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_status = status_ff;

`ifndef NO_ASSERTIONS
   a_strobe_after_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == ffa_pkg::S_DONE |=> rsp_strobe)
      else $error("missing result strobe");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CntBits'(1) && count_ff <= CntBits'(MAX_SEGMENTS))
      else $error("segment count out of range");
   a_used_le_peak: assert property (@(posedge clock) disable iff (reset)
      used_ff <= peak_ff)
      else $error("used exceeds peak");
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> state_ff == ffa_pkg::S_IDLE)
      else $error("strobe while busy");
`endif

endmodule

// File: hw/rtl/first_fit_allocator.sv
// Top level: first-fit arena allocator with split and coalesce.
// A split shifts the entries after the found one up; each merge shifts later ones down.
// One word at a time: busy drops in the strobe cycle; the receiver cannot stall
// and rsp_strobe lasts one cycle. Synchronous active-high reset, or a
// csr_arena_bytes write while idle, re-inits to one free segment; no clearing pass.
module first_fit_allocator #(
   parameter int MAX_SEGMENTS = ffa_pkg::MaxSegmentsDefault,
   parameter int HEADER_BYTES = ffa_pkg::HeaderBytesDefault,
   parameter int ADDR_BITS    = ffa_pkg::AddrBitsDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [ffa_pkg::SizeBits-1:0]   csr_arena_bytes,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_action,
   input  logic [ffa_pkg::SizeBits-1:0]   req_request_bytes,
   input  logic [ffa_pkg::OffsetBits-1:0] req_payload_offset,
   output logic                           rsp_strobe,
   output logic [1:0]                     rsp_status
);

   // All table walking lives in the sequencer; the table has one write and one read port.
   ffa_ctrl #(
      .MAX_SEGMENTS(MAX_SEGMENTS),
      .HEADER_BYTES(HEADER_BYTES),
      .ADDR_BITS(ADDR_BITS)
   ) u_ctrl (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_wdata(csr_arena_bytes),
      .start(start), .busy(busy),
      .req_action(req_action), .req_request_bytes(req_request_bytes),
      .req_payload_offset(req_payload_offset),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status));

endmodule

// File: sim/first_fit_allocator_checker.sv
// Checker: watches the allocator's channels, predicts each status word and compares.
`timescale 1ns / 100ps
module first_fit_allocator_checker #(
   parameter int MAX_SEGMENTS = ffa_pkg::MaxSegmentsDefault,
   parameter int HEADER_BYTES = ffa_pkg::HeaderBytesDefault,
   parameter int ADDR_BITS    = ffa_pkg::AddrBitsDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write,
   input  logic [ffa_pkg::SizeBits-1:0]   csr_arena_bytes,
   input  logic                           start,
   input  logic                           busy,
   input  logic                           req_action,
   input  logic [ffa_pkg::SizeBits-1:0]   req_request_bytes,
   input  logic [ffa_pkg::OffsetBits-1:0] req_payload_offset,
   input  logic                           rsp_strobe,
   input  logic [1:0]                     rsp_status,
   output int                             fail_count,
   output int                             pending_count
);

   logic [31:0] seg_base [MAX_SEGMENTS];
   logic [31:0] seg_len  [MAX_SEGMENTS];
   logic        seg_open [MAX_SEGMENTS];
   int          seg_total;
   logic [31:0] used_bytes, peak_bytes;
   logic [ffa_pkg::SizeBits-1:0] arena_raw;
   ffa_pkg::status_type status_queue [$];

   function automatic logic [31:0] arena_aligned(logic [ffa_pkg::SizeBits-1:0] raw);
      logic [32:0] a;
      logic [32:0] lim;
      a   = ({12'd0, raw} + 33'd7) & ~33'd7;
      lim = 33'd1 << ADDR_BITS;
      if (a > 33'(ffa_pkg::ArenaCap)) a = 33'(ffa_pkg::ArenaCap);
      if (a > lim) a = lim & ~33'd7;
      return a[31:0];
   endfunction

   task automatic arena_init();
      for (int k = 0; k < MAX_SEGMENTS; k++) begin
         seg_base[k] = 0; seg_len[k] = 0; seg_open[k] = 0;
      end
      seg_len[0]  = arena_aligned(arena_raw);
      seg_open[0] = 1;
      seg_total   = 1;
      used_bytes  = 0;
      peak_bytes  = 0;
   endtask

   function automatic void drop_segment(int j);
      for (int k = j; k + 1 < seg_total; k++) begin
         seg_base[k] = seg_base[k+1]; seg_len[k] = seg_len[k+1]; seg_open[k] = seg_open[k+1];
      end
      seg_total--;
   endfunction

   function automatic ffa_pkg::status_type allocate(logic [ffa_pkg::SizeBits-1:0] bytes);
      logic [32:0] need;
      int i;
      if (bytes == 0) return ffa_pkg::ST_IGNORED;
      need = ({12'd0, bytes} + 33'(HEADER_BYTES) + 33'd7) & ~33'd7;
      for (i = 0; i < seg_total; i++)
         if (seg_open[i] && {1'b0, seg_len[i]} >= need) break;
      if (i >= seg_total) return ffa_pkg::ST_NOFIT;
      if ({1'b0, seg_len[i]} >= need + 33'(HEADER_BYTES) + 33'd16 &&
          seg_total < MAX_SEGMENTS) begin
         for (int k = seg_total; k > i + 1; k--) begin
            seg_base[k] = seg_base[k-1]; seg_len[k] = seg_len[k-1]; seg_open[k] = seg_open[k-1];
         end
         seg_base[i+1] = seg_base[i] + need[31:0];
         seg_len[i+1]  = seg_len[i] - need[31:0];
         seg_open[i+1] = 1;
         seg_len[i]    = need[31:0];
         seg_total++;
      end
      seg_open[i] = 0;
      used_bytes += seg_len[i];
      if (used_bytes > peak_bytes) peak_bytes = used_bytes;
      return ffa_pkg::ST_DONE;
   endfunction

   function automatic ffa_pkg::status_type release_block(logic [ffa_pkg::OffsetBits-1:0] off);
      int i;
      if (off == 0) return ffa_pkg::ST_IGNORED;
      for (i = 0; i < seg_total; i++)
         if (!seg_open[i] && {1'b0, seg_base[i]} + 33'(HEADER_BYTES) == {13'd0, off}) break;
      if (i >= seg_total) return ffa_pkg::ST_BADFREE;
      used_bytes -= seg_len[i];
      seg_open[i] = 1;
      if (i + 1 < seg_total && seg_open[i+1]) begin
         seg_len[i] += seg_len[i+1];
         drop_segment(i + 1);
      end
      if (i > 0 && seg_open[i-1]) begin
         seg_len[i-1] += seg_len[i];
         drop_segment(i);
      end
      return ffa_pkg::ST_DONE;
   endfunction

   always @(posedge clock) begin
      ffa_pkg::status_type want;
      if (reset) begin
         arena_raw = ffa_pkg::ArenaResetBytes;
         arena_init();
         status_queue.delete();
         fail_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (status_queue.size() == 0) begin
               $display("%0t: unexpected status word: expected none, actual %0d",
                        $time, rsp_status);
               fail_count++;
            end else begin
               want = status_queue.pop_front();
               if (rsp_status !== want) begin
                  $display("%0t: status mismatch: expected %0d, actual %0d",
                           $time, want, rsp_status);
                  fail_count++;
               end
            end
         end
         if (csr_write) begin
            arena_raw = csr_arena_bytes;
            arena_init();
         end
         if (start && !busy)
            status_queue.push_back(req_action == ffa_pkg::ACT_FREE ?
                                   release_block(req_payload_offset) :
                                   allocate(req_request_bytes));
      end
      pending_count = status_queue.size();
   end

endmodule

// File: sim/first_fit_allocator_tb.sv
// Testbench top: stimulus, configuration phases and verdict for the allocator.
`timescale 1ns / 100ps
module first_fit_allocator_tb;

   logic                           clock = 0;
   logic                           reset = 1;
   logic                           csr_write = 0;
   logic [ffa_pkg::SizeBits-1:0]   csr_arena_bytes = '0;
   logic                           start = 0;
   logic                           busy;
   logic                           req_action = 0;
   logic [ffa_pkg::SizeBits-1:0]   req_request_bytes = '0;
   logic [ffa_pkg::OffsetBits-1:0] req_payload_offset = '0;
   logic                           rsp_strobe;
   logic [1:0]                     rsp_status;
   int                             fail_count, pending_count;

   // offsets handed out so far, as the stimulus thinks of them; frees draw here
   logic [ffa_pkg::OffsetBits-1:0] live_offsets [$];
   logic [ffa_pkg::OffsetBits-1:0] next_guess;
   int                             words_sent, allocs_sent, frees_sent;

   always #6 clock = ~clock;

   first_fit_allocator uut (
      .clock, .reset, .csr_write, .csr_arena_bytes, .start, .busy,
      .req_action, .req_request_bytes, .req_payload_offset,
      .rsp_strobe, .rsp_status
   );

   first_fit_allocator_checker checker_i (
      .clock, .reset, .csr_write, .csr_arena_bytes, .start, .busy,
      .req_action, .req_request_bytes, .req_payload_offset,
      .rsp_strobe, .rsp_status, .fail_count, .pending_count
   );

   // hard stop: 1391 words, each up to a worst-case walk, plus gaps
   initial begin
      #(12 * 3000000);
      $display("Simulation FAILED");
      $finish;
   end

   // one word: a random gap on falling edges leaves the last one behind, then
   // hold start until accepted; drop start after
   task automatic send_word(ffa_pkg::action_type act, logic [ffa_pkg::SizeBits-1:0] bytes,
                            logic [ffa_pkg::OffsetBits-1:0] off);
      int gap;
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) gap = 0;
      repeat (gap + 1) @(negedge clock);
      start              <= 1;
      req_action         <= act;
      req_request_bytes  <= bytes;
      req_payload_offset <= off;
      do @(posedge clock); while (busy);
      @(negedge clock);
      start <= 0;
      // junk on unused fields while idle
      req_request_bytes  <= ffa_pkg::SizeBits'($urandom);
      req_payload_offset <= ffa_pkg::OffsetBits'($urandom);
      words_sent++;
      if (act == ffa_pkg::ACT_ALLOC) allocs_sent++; else frees_sent++;
   endtask

   // wait out all status words plus the longest walk before touching the csr
   task automatic drain();
      while (pending_count != 0) @(negedge clock);
      repeat (6 * ffa_pkg::MaxSegmentsDefault + 20) @(negedge clock);
   endtask

   task automatic write_arena(logic [ffa_pkg::SizeBits-1:0] bytes);
      drain();
      csr_write       <= 1;
      csr_arena_bytes <= bytes;
      @(negedge clock);
      csr_write       <= 0;
      csr_arena_bytes <= ffa_pkg::SizeBits'($urandom);
      live_offsets.delete();
      next_guess = ffa_pkg::OffsetBits'(ffa_pkg::HeaderBytesDefault);
   endtask

   // allocate and remember the payload offset the first-fit walk should give
   task automatic alloc_bytes(logic [ffa_pkg::SizeBits-1:0] bytes);
      send_word(ffa_pkg::ACT_ALLOC, bytes, ffa_pkg::OffsetBits'($urandom));
      if (bytes != 0) begin
         live_offsets.push_back(next_guess);
         next_guess += ffa_pkg::OffsetBits'((bytes + ffa_pkg::HeaderBytesDefault + 7) & ~7);
      end
   endtask

   // random phase: mostly real frees and sized allocs, some junk
   task automatic random_phase(int count, int max_bytes);
      int pick, idx;
      logic [ffa_pkg::SizeBits-1:0] bytes;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            bytes = (pick < 3) ? 21'($urandom) : 21'($urandom_range(1, max_bytes));
            alloc_bytes(bytes);
         end else if (pick < 85 && live_offsets.size() != 0) begin
            idx = $urandom_range(0, live_offsets.size() - 1);
            send_word(ffa_pkg::ACT_FREE, 21'($urandom), live_offsets[idx]);
            // keep some for double frees
            if ($urandom_range(0, 4) != 0) live_offsets.delete(idx);
         end else if (pick < 92) begin
            send_word(ffa_pkg::ACT_FREE, 21'($urandom), 20'($urandom));
         end else if (pick < 96) begin
            send_word(ffa_pkg::ACT_FREE, 21'($urandom), 20'($urandom_range(1, 4096)) & ~20'd7);
         end else begin
            send_word($urandom_range(0, 1) ? ffa_pkg::ACT_FREE : ffa_pkg::ACT_ALLOC, '0, '0);
         end
      end
   endtask

   initial begin
      words_sent = 0; allocs_sent = 0; frees_sent = 0;
      next_guess = ffa_pkg::OffsetBits'(ffa_pkg::HeaderBytesDefault);
      repeat (10) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // directed: zero, null, extremes, exact fit, bad and double free
      send_word(ffa_pkg::ACT_ALLOC, '0, '0);
      send_word(ffa_pkg::ACT_FREE, '0, '0);
      send_word(ffa_pkg::ACT_ALLOC, 21'h1FFFFF, '0);
      send_word(ffa_pkg::ACT_ALLOC, 21'd1048576, '0);
      send_word(ffa_pkg::ACT_FREE, '0, 20'hFFFFF);
      send_word(ffa_pkg::ACT_FREE, '0, 20'd40);
      alloc_bytes(21'd1);
      alloc_bytes(21'd24);
      alloc_bytes(21'd100);
      send_word(ffa_pkg::ACT_FREE, '0, live_offsets[1]);
      send_word(ffa_pkg::ACT_FREE, '0, live_offsets[1]);
      send_word(ffa_pkg::ACT_FREE, '0, live_offsets[0]);
      send_word(ffa_pkg::ACT_FREE, '0, live_offsets[2]);
      alloc_bytes(21'(65536 - 40));
      alloc_bytes(21'd8);

      // empty arena: every alloc misses
      write_arena('0);
      send_word(ffa_pkg::ACT_ALLOC, 21'd1, '0);
      send_word(ffa_pkg::ACT_ALLOC, 21'h1FFFFF, '0);
      send_word(ffa_pkg::ACT_FREE, '0, 20'd40);

      // tiny arena, odd size rounds up
      write_arena(21'd97);
      alloc_bytes(21'd56);
      alloc_bytes(21'd1);
      random_phase(150, 64);

      // table fills: many small allocs in a big arena
      write_arena(21'd8000);
      for (int n = 0; n < 70; n++) alloc_bytes(21'($urandom_range(1, 40)));
      random_phase(250, 200);

      // widest arena, above the cap
      write_arena(21'h1FFFFF);
      random_phase(300, 30000);
      alloc_bytes(21'(1048576 - 40));

      write_arena(21'd1048576);
      random_phase(250, 1 << 18);

      write_arena(ffa_pkg::ArenaResetBytes);
      random_phase(350, 2000);

      drain();
      $display("Ran %0d words (%0d allocates, %0d frees) over arenas from empty",
               words_sent, allocs_sent, frees_sent);
      $display("to the full cap, with table-full, coalescing and bad frees.");
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
hw/rtl/ffa_pkg.sv
hw/rtl/ffa_seg_table.sv
hw/rtl/ffa_ctrl.sv
hw/rtl/first_fit_allocator.sv
sim/first_fit_allocator_checker.sv
sim/first_fit_allocator_tb.sv
